@@ rtl/scaled_presentation_clock_top_assert.svh @@
// Assertion macros for the presentation clock.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef SCALED_PRESENTATION_CLOCK_TOP_ASSERT_SVH
`define SCALED_PRESENTATION_CLOCK_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spc: implication failed");
// next-cycle implication
`define SPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spc: next-cycle check failed");
`else
`define SPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/spc_pkg.sv @@
package spc_pkg;

    // default sizing
    localparam int DEF_TIME_BITS       = 48;
    localparam int DEF_ELAPSED_BITS    = 40;
    localparam int DEF_SPEED_FRAC_BITS = 8;

    // fixed field widths
    localparam int PTS_BITS   = 48;
    localparam int SPEED_BITS = 16;
    localparam int OUT_BITS   = 48;
    localparam int DELAY_BITS = 49;

    // scaled elapsed time is capped at 2^62
    localparam int CAP_SHIFT = 62;
    localparam int Q_BITS    = CAP_SHIFT + 1;

    typedef logic [2:0] t_kind;

    localparam t_kind K_TICK   = 3'd0;
    localparam t_kind K_SEEK   = 3'd1;
    localparam t_kind K_SPEED  = 3'd2;
    localparam t_kind K_PAUSE  = 3'd3;
    localparam t_kind K_RESUME = 3'd4;
    localparam t_kind K_RESET  = 3'd5;
    localparam t_kind K_QUERY  = 3'd6;

    // per-request flags carried from the state stage to the result stage
    typedef struct packed {
        logic paused;
        logic query;
    } t_flags;

endpackage

@@ rtl/scaled_presentation_clock_top.sv @@
// Scaled presentation clock.
// Request channel: i_in_valid / o_in_ready with i_kind, i_pts_value and
// i_speed_value. Kinds: tick (one ms passes), seek, set speed, pause, resume,
// reset and frame-delay query.
// Result channel: o_out_valid / i_out_ready with o_current_time (clock time
// after the request) and o_frame_delay (pts minus that time, zero unless query).
// Every request gives exactly one result, in order.
// Throughput: one request per cycle while i_out_ready is high. Pipeline is
// input register, state stage, result register; a request passes each in
// turn. The per-cycle state update (tick accumulation of elapsed * speed,
// or folding the scaled elapsed time into the base) sets the clock rate.
// Reset (i_rst_n low, synchronous): base 0, elapsed 0, speed 1.0, running;
// all stages empty.
// When the receiver stalls, each stage holds its request while free stages
// upstream keep filling, so up to three requests are taken before
// o_in_ready drops.
`include "scaled_presentation_clock_top_assert.svh"

module scaled_presentation_clock_top
    import spc_pkg::*;
#(
    parameter int TIME_BITS       = DEF_TIME_BITS,
    parameter int ELAPSED_BITS    = DEF_ELAPSED_BITS,
    parameter int SPEED_FRAC_BITS = DEF_SPEED_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_kind,
    input  logic signed [PTS_BITS-1:0]   i_pts_value,
    input  logic [SPEED_BITS-1:0]        i_speed_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [OUT_BITS-1:0]   o_current_time,
    output logic signed [DELAY_BITS-1:0] o_frame_delay
);

    // input register
    logic                       r_in_valid;
    t_kind                      r_kind;
    logic signed [PTS_BITS-1:0] r_pts;
    logic [SPEED_BITS-1:0]      r_speed;

    // state stage to result stage
    logic                        s1_ready;
    logic                        s1_valid;
    logic                        s2_ready;
    logic signed [TIME_BITS-1:0] s1_base;
    logic [Q_BITS-1:0]           s1_q;
    t_flags                      s1_flags;
    logic signed [PTS_BITS-1:0]  s1_pts;

    assign o_in_ready = !r_in_valid || s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind  <= i_kind;
            r_pts   <= i_pts_value;
            r_speed <= i_speed_value;
        end
    end

    spc_state #(
        .TIME_BITS       (TIME_BITS),
        .ELAPSED_BITS    (ELAPSED_BITS),
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (s1_ready),
        .i_kind  (r_kind),
        .i_pts   (r_pts),
        .i_speed (r_speed),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_base  (s1_base),
        .o_q     (s1_q),
        .o_flags (s1_flags),
        .o_pts   (s1_pts)
    );

    spc_result #(
        .TIME_BITS (TIME_BITS)
    ) u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s1_valid),
        .o_ready        (s2_ready),
        .i_base         (s1_base),
        .i_q            (s1_q),
        .i_flags        (s1_flags),
        .i_pts          (s1_pts),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_current_time (o_current_time),
        .o_frame_delay  (o_frame_delay)
    );

    // reset request leaves a clean snapshot
    `SPC_ASSERT_NXT(a_reset_clears, i_clk, i_rst_n,
        r_in_valid && s1_ready && (r_kind == K_RESET),
        (s1_base == '0) && (s1_q == '0) && !s1_flags.paused)
    // seek restarts the elapsed count
    `SPC_ASSERT_NXT(a_seek_zero_q, i_clk, i_rst_n,
        r_in_valid && s1_ready && (r_kind == K_SEEK), s1_q == '0)
    // pause always ends paused
    `SPC_ASSERT_NXT(a_pause_sets, i_clk, i_rst_n,
        r_in_valid && s1_ready && (r_kind == K_PAUSE), s1_flags.paused)
    // an empty state stage never blocks the input
    `SPC_ASSERT_IMP(a_empty_ready, i_clk, i_rst_n, !s1_valid, o_in_ready)

endmodule

@@ rtl/spc_state.sv @@
module spc_state
    import spc_pkg::*;
#(
    parameter int TIME_BITS       = DEF_TIME_BITS,
    parameter int ELAPSED_BITS    = DEF_ELAPSED_BITS,
    parameter int SPEED_FRAC_BITS = DEF_SPEED_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  t_kind                       i_kind,
    input  logic signed [PTS_BITS-1:0]  i_pts,
    input  logic [SPEED_BITS-1:0]       i_speed,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [TIME_BITS-1:0] o_base,
    output logic [Q_BITS-1:0]           o_q,
    output t_flags                      o_flags,
    output logic signed [PTS_BITS-1:0]  o_pts
);

    localparam int ACC_BITS = ELAPSED_BITS + SPEED_BITS;
    localparam int XW       = (ACC_BITS > Q_BITS) ? ACC_BITS : Q_BITS;
    localparam int SW       = ((TIME_BITS > Q_BITS) ? TIME_BITS : Q_BITS) + 2;
    localparam logic [XW-1:0]        CAP  = XW'(1) << CAP_SHIFT;
    localparam logic signed [SW-1:0] TMAX = (SW'(1) << (TIME_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] TMIN = -TMAX - SW'(1);
    localparam logic [SPEED_BITS-1:0] RATE_ONE = SPEED_BITS'(32'd1 << SPEED_FRAC_BITS);

    // clock state; r_acc holds elapsed * rate while running, r_q its capped scaled form
    logic signed [TIME_BITS-1:0] r_base, n_base;
    logic [ELAPSED_BITS-1:0]     r_elapsed, n_elapsed;
    logic [ACC_BITS-1:0]         r_acc, n_acc;
    logic [Q_BITS-1:0]           r_q, n_q;
    logic [SPEED_BITS-1:0]       r_rate, n_rate;
    logic                        r_paused, n_paused;

    // snapshot handed to the result stage
    logic                        r_valid;
    logic signed [TIME_BITS-1:0] r_s_base;
    logic [Q_BITS-1:0]           r_s_q;
    t_flags                      r_s_flags;
    logic signed [PTS_BITS-1:0]  r_s_pts;

    logic                        fire;
    logic signed [SW-1:0]        base_w, q_w, run_w, fold_w, pts_w, seek_w;
    logic [XW-1:0]               q_ext;

    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;

    // running time of the current state, saturated high; seek target clamped to the clock range
    always_comb begin
        base_w = SW'(r_base);
        q_w    = SW'(r_q);
        run_w  = base_w + q_w;
        fold_w = (run_w > TMAX) ? TMAX : run_w;
        pts_w  = SW'(i_pts);
        if (pts_w > TMAX) begin
            seek_w = TMAX;
        end else if (pts_w < TMIN) begin
            seek_w = TMIN;
        end else begin
            seek_w = pts_w;
        end
    end

    // next state per request kind
    always_comb begin
        n_base    = r_base;
        n_elapsed = r_elapsed;
        n_acc     = r_acc;
        n_rate    = r_rate;
        n_paused  = r_paused;
        unique case (i_kind)
            K_TICK: begin
                if (r_elapsed != '1) begin
                    n_elapsed = r_elapsed + ELAPSED_BITS'(1);
                    if (!r_paused) begin
                        n_acc = r_acc + ACC_BITS'(r_rate);
                    end
                end
            end
            K_SEEK: begin
                n_base    = TIME_BITS'(seek_w);
                n_elapsed = '0;
                n_acc     = '0;
            end
            K_SPEED: begin
                if (!r_paused) begin
                    n_base    = TIME_BITS'(fold_w);
                    n_elapsed = '0;
                    n_acc     = '0;
                end
                n_rate = i_speed;
            end
            K_PAUSE: begin
                if (!r_paused) begin
                    n_base    = TIME_BITS'(fold_w);
                    n_elapsed = '0;
                    n_acc     = '0;
                    n_paused  = 1'b1;
                end
            end
            K_RESUME: begin
                if (r_paused) begin
                    n_elapsed = '0;
                    n_acc     = '0;
                    n_paused  = 1'b0;
                end
            end
            K_RESET: begin
                n_base    = '0;
                n_elapsed = '0;
                n_acc     = '0;
                n_rate    = RATE_ONE;
                n_paused  = 1'b0;
            end
            default: begin
            end
        endcase
        // scale down and cap
        q_ext = XW'(n_acc >> SPEED_FRAC_BITS);
        n_q   = (q_ext > CAP) ? Q_BITS'(CAP) : Q_BITS'(q_ext);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_elapsed <= '0;
            r_acc     <= '0;
            r_q       <= '0;
            r_rate    <= RATE_ONE;
            r_paused  <= 1'b0;
        end else if (fire) begin
            r_base    <= n_base;
            r_elapsed <= n_elapsed;
            r_acc     <= n_acc;
            r_q       <= n_q;
            r_rate    <= n_rate;
            r_paused  <= n_paused;
        end
    end

    // snapshot stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // snapshot payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s_base         <= n_base;
            r_s_q            <= n_q;
            r_s_flags.paused <= n_paused;
            r_s_flags.query  <= (i_kind == K_QUERY);
            r_s_pts          <= i_pts;
        end
    end

    assign o_valid = r_valid;
    assign o_base  = r_s_base;
    assign o_q     = r_s_q;
    assign o_flags = r_s_flags;
    assign o_pts   = r_s_pts;

endmodule

@@ rtl/spc_result.sv @@
module spc_result
    import spc_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [TIME_BITS-1:0] i_base,
    input  logic [Q_BITS-1:0]           i_q,
    input  t_flags                      i_flags,
    input  logic signed [PTS_BITS-1:0]  i_pts,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [OUT_BITS-1:0]  o_current_time,
    output logic signed [DELAY_BITS-1:0] o_frame_delay
);

    localparam int SW = ((TIME_BITS > Q_BITS) ? TIME_BITS : Q_BITS) + 2;
    localparam logic signed [SW-1:0] TMAX = (SW'(1) << (TIME_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] TMIN = -TMAX - SW'(1);
    localparam logic signed [SW-1:0] OMAX = (SW'(1) << (OUT_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] OMIN = -OMAX - SW'(1);
    // tightest of the clock range and the output range
    localparam logic signed [SW-1:0] HI = (TIME_BITS > OUT_BITS) ? OMAX : TMAX;
    localparam logic signed [SW-1:0] LO = (TIME_BITS > OUT_BITS) ? OMIN : TMIN;

    logic                         r_valid;
    logic signed [OUT_BITS-1:0]   r_cur;
    logic signed [DELAY_BITS-1:0] r_delay;

    logic signed [SW-1:0] base_w, q_w, pts_w, v_w, d_w, cur_w, delay_w;

    assign o_ready = !r_valid || i_ready;

    // time and delay in parallel; clamping picks the matching delay, zeroed unless query
    always_comb begin
        base_w = SW'(i_base);
        q_w    = i_flags.paused ? '0 : SW'(i_q);
        pts_w  = SW'(i_pts);
        v_w    = base_w + q_w;
        d_w    = pts_w - base_w - q_w;
        if (v_w > HI) begin
            cur_w   = HI;
            delay_w = pts_w - HI;
        end else if (v_w < LO) begin
            cur_w   = LO;
            delay_w = pts_w - LO;
        end else begin
            cur_w   = v_w;
            delay_w = d_w;
        end
        if (!i_flags.query) begin
            delay_w = '0;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cur   <= OUT_BITS'(cur_w);
            r_delay <= DELAY_BITS'(delay_w);
        end
    end

    assign o_valid        = r_valid;
    assign o_current_time = r_cur;
    assign o_frame_delay  = r_delay;

endmodule
